/* src/bmp_rle8_decoder_assert.svh */
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_assert.svh
// Assertion macros used by the RLE8 decoder checker.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE8_DECODER_ASSERT_SVH
`define BMP_RLE8_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/brle_pkg.sv */
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the BMP RLE8 decoder.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned LenW    = 8;
  localparam int unsigned ImgW    = 24;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // Second byte of an escape pair
  localparam logic [CodeW-1:0] EscEol   = 8'd0;
  localparam logic [CodeW-1:0] EscEob   = 8'd1;
  localparam logic [CodeW-1:0] EscDelta = 8'd2;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_RUN,
    CMD_END
  } cmd_kind_t;

  // Command handed from the parser to the run executor
  typedef struct packed {
    cmd_kind_t         kind;
    logic              restart;
    logic [CodeW-1:0]  value;
    logic [LenW-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic [ImgW-1:0]   start_index;
    logic [LenW-1:0]   run_length;
    logic [CodeW-1:0]  pixel_value;
    logic              last;
    logic              overflow;
  } result_t;

endpackage

/* src/bmp_rle8_decoder.sv */
// ----------------------------------------------------------------------------
// bmp_rle8_decoder
// BMP RLE8 stream decoder producing (value, length, start index) runs.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one encoded byte per beat; in_tuser=1 marks the first byte of an
//           image and restarts the decoder before that byte is parsed.
//   out_* : one run per beat; tlast flags end of bitmap or an overflow stop,
//           tuser flags a run clipped at the image size.
//   cfg_* : image size in bytes, written while the decoder is idle.
// Throughput is one byte per cycle while the command queue has room. A
// parser stage classifies each byte, a four-entry command queue follows,
// and an executor computes the position and clipping into a registered
// output: a run is registered once its command leaves the queue. The
// executor does one add and compare per cycle, which sets the clock limit.
// When the receiver stalls, the output register holds its run; the queue
// absorbs up to four more commands before in_tready drops.
// Reset (synchronous, active low) clears phase, position, queue and size.
// Pad bytes, end of line and delta escapes are consumed with no output; after
// a stop every byte is dropped until the next in_tuser=1 beat.
// ----------------------------------------------------------------------------
module bmp_rle8_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,   // image_bytes
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,      // [7:0] code_byte
  input  logic         in_tuser,      // first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,     // [7:0] pixel_value, [15:8] run_length,
                                      // [39:16] start_index
  output logic         out_tlast,
  output logic         out_tuser      // overflow
);

  logic [brle_pkg::ImgW-1:0]  image_bytes_r;
  logic                       push_valid, push_ready;
  brle_pkg::cmd_t             push_cmd;
  logic                       pop_valid, pop_ready;
  brle_pkg::cmd_t             pop_cmd;
  brle_pkg::result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_bytes_r <= '0;
    end else if (cfg_wr_en) begin
      image_bytes_r <= cfg_wr_data;
    end
  end

  brle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .code_byte  (in_tdata),
    .first_byte (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  brle_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  brle_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_bytes (image_bytes_r),
    .cmd_valid   (pop_valid),
    .cmd_ready   (pop_ready),
    .cmd         (pop_cmd),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {res.start_index, res.run_length, res.pixel_value};
  assign out_tlast = res.last;
  assign out_tuser = res.overflow;

endmodule

/* src/brle_fifo.sv */
// ----------------------------------------------------------------------------
// brle_fifo
// Small command queue between the byte parser and the run executor.
// ----------------------------------------------------------------------------
module brle_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  brle_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output brle_pkg::cmd_t  pop_cmd
);

  brle_pkg::cmd_t                  mem_r [brle_pkg::FifoDepth];
  logic [brle_pkg::FifoAw-1:0]     wr_ptr_r;
  logic [brle_pkg::FifoAw-1:0]     rd_ptr_r;
  logic [brle_pkg::FifoAw:0]       count_r;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count_r != (brle_pkg::FifoAw+1)'(brle_pkg::FifoDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/brle_front.sv */
// ----------------------------------------------------------------------------
// brle_front
// Byte parser: tracks pair / literal / pad phase and turns bytes into commands.
// ----------------------------------------------------------------------------
module brle_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [brle_pkg::CodeW-1:0]  code_byte,
  input  logic                        first_byte,
  output logic                        push_valid,
  input  logic                        push_ready,
  output brle_pkg::cmd_t              push_cmd
);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_SECOND,
    PH_LITERAL,
    PH_PAD,
    PH_STOPPED
  } phase_t;

  phase_t                        phase_r, phase_nxt, phase_eff;
  logic [brle_pkg::CodeW-1:0]    held_r, held_nxt;
  logic [brle_pkg::LenW-1:0]     left_r, left_nxt;
  logic                          odd_r, odd_nxt;
  brle_pkg::cmd_t                cmd;

  assign in_ready = push_ready;

  always_comb begin
    phase_eff   = first_byte ? PH_OPCODE : phase_r;
    phase_nxt   = phase_eff;
    held_nxt    = held_r;
    left_nxt    = left_r;
    odd_nxt     = odd_r;
    cmd.kind    = brle_pkg::CMD_NONE;
    cmd.restart = first_byte;
    cmd.value   = code_byte;
    cmd.len     = brle_pkg::LenW'(1);
    case (phase_eff)
      PH_OPCODE: begin
        held_nxt  = code_byte;
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        if (held_r != '0) begin
          cmd.kind  = brle_pkg::CMD_RUN;
          cmd.len   = held_r;
          phase_nxt = PH_OPCODE;
        end else if (code_byte == brle_pkg::EscEob) begin
          cmd.kind  = brle_pkg::CMD_END;
          phase_nxt = PH_STOPPED;
        end else if (code_byte == brle_pkg::EscEol || code_byte == brle_pkg::EscDelta) begin
          phase_nxt = PH_OPCODE;
        end else begin
          left_nxt  = code_byte;
          odd_nxt   = code_byte[0];
          phase_nxt = PH_LITERAL;
        end
      end
      PH_LITERAL: begin
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          phase_nxt = odd_r ? PH_PAD : PH_OPCODE;
        end
        cmd.kind = brle_pkg::CMD_RUN;
      end
      PH_PAD: begin
        phase_nxt = PH_OPCODE;
      end
      PH_STOPPED: begin
        phase_nxt = PH_STOPPED;
      end
      default: begin
        phase_nxt = PH_OPCODE;
      end
    endcase
  end

  // Forward restarts even when the byte itself yields no run
  assign push_valid = in_valid && ((cmd.kind != brle_pkg::CMD_NONE) || first_byte);
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      held_r  <= '0;
      left_r  <= '0;
      odd_r   <= 1'b0;
    end else if (in_valid && in_ready) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      left_r  <= left_nxt;
      odd_r   <= odd_nxt;
    end
  end

endmodule

/* src/brle_back.sv */
// ----------------------------------------------------------------------------
// brle_back
// Run executor: places runs in the output, clips at image size, holds result.
// ----------------------------------------------------------------------------
module brle_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [brle_pkg::ImgW-1:0]   image_bytes,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  brle_pkg::cmd_t              cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output brle_pkg::result_t           res
);

  logic                          out_valid_r;
  brle_pkg::result_t             res_r, res_nxt;
  logic [brle_pkg::ImgW-1:0]     pos_r, pos_nxt, pos_eff;
  logic                          stopped_r, stopped_nxt, stopped_eff;
  logic [brle_pkg::ImgW:0]       diff;
  logic [brle_pkg::ImgW-1:0]     room;
  logic                          clip;
  logic                          emit;

  assign cmd_ready = !out_valid_r || res_ready;
  assign res_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    pos_eff     = cmd.restart ? '0 : pos_r;
    stopped_eff = cmd.restart ? 1'b0 : stopped_r;
    diff        = {1'b0, image_bytes} - {1'b0, pos_eff};
    room        = diff[brle_pkg::ImgW] ? '0 : diff[brle_pkg::ImgW-1:0];
    clip        = {{(brle_pkg::ImgW-brle_pkg::LenW){1'b0}}, cmd.len} > room;

    pos_nxt             = pos_eff;
    stopped_nxt         = stopped_eff;
    emit                = 1'b0;
    res_nxt.pixel_value = cmd.value;
    res_nxt.run_length  = cmd.len;
    res_nxt.start_index = pos_eff;
    res_nxt.last        = 1'b0;
    res_nxt.overflow    = 1'b0;
    if (!stopped_eff) begin
      case (cmd.kind)
        brle_pkg::CMD_RUN: begin
          emit = 1'b1;
          if (clip) begin
            // Clip to the space left and stop
            res_nxt.run_length = room[brle_pkg::LenW-1:0];
            res_nxt.last       = 1'b1;
            res_nxt.overflow   = 1'b1;
            pos_nxt            = image_bytes;
            stopped_nxt        = 1'b1;
          end else begin
            pos_nxt = pos_eff + {{(brle_pkg::ImgW-brle_pkg::LenW){1'b0}}, cmd.len};
          end
        end
        brle_pkg::CMD_END: begin
          emit                = 1'b1;
          res_nxt.pixel_value = '0;
          res_nxt.run_length  = '0;
          res_nxt.last        = 1'b1;
          stopped_nxt         = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      stopped_r   <= 1'b0;
    end else if (cmd_ready) begin
      out_valid_r <= cmd_valid && emit;
      if (cmd_valid) begin
        pos_r     <= pos_nxt;
        stopped_r <= stopped_nxt;
        res_r     <= res_nxt;
      end
    end
  end

endmodule

/* src/brle_checker.sv */
// ----------------------------------------------------------------------------
// brle_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
`include "bmp_rle8_decoder_assert.svh"

module brle_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [39:0]  out_tdata,
  input  logic         out_tlast,
  input  logic         out_tuser
);

  `BRLE_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")
  `BRLE_ASSERT_NOW(a_ovf_is_last, clk, rst_n, out_tvalid && out_tuser, out_tlast, "overflow run without last")
  `BRLE_ASSERT_NOW(a_end_marker, clk, rst_n, out_tvalid && out_tlast && !out_tuser, out_tdata[15:0] == 16'd0, "end marker carries data")
  `BRLE_ASSERT_NOW(a_run_nonzero, clk, rst_n, out_tvalid && !out_tlast, out_tdata[15:8] != 8'd0, "empty run mid-stream")

endmodule

bind bmp_rle8_decoder brle_checker u_brle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BMP RLE8 stream decoder.
// ----------------------------------------------------------------------------
// A short directed sequence covers full-length runs, every escape, odd and
// even literals, exact fill, a size lowered below the write position, a zero
// size and bytes dropped after a stop. Random images follow, mostly
// well-formed command streams with some noise and abandoned images, under a
// range of image sizes. Every accepted byte updates a local decoder model
// whose predicted runs are checked against each output beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TotalBytes    = 1450;
  localparam int unsigned QuietAfter    = 1250;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned WatchdogLimit = 1000;

  typedef enum logic [2:0] {
    EXP_CODE,
    EXP_SECOND,
    IN_LITERAL,
    AT_PAD,
    HALTED
  } parse_state_t;

  class rle_run_scoreboard;
    logic [23:0]  img_size;
    parse_state_t state;
    logic [7:0]   held_code;
    logic [7:0]   lit_left;
    bit           lit_odd;
    logic [24:0]  wr_pos;
    brle_pkg::result_t runs_due[$];
    int unsigned  errors;
    int unsigned  bytes_taken;
    int unsigned  bytes_used;
    int unsigned  runs_seen;
    int unsigned  stops_seen;
    int unsigned  ends_seen;

    function new();
      img_size    = '0;
      errors      = 0;
      bytes_taken = 0;
      bytes_used  = 0;
      runs_seen   = 0;
      stops_seen  = 0;
      ends_seen   = 0;
      restart();
    endfunction

    function void restart();
      state     = EXP_CODE;
      held_code = '0;
      lit_left  = '0;
      lit_odd   = 1'b0;
      wr_pos    = '0;
    endfunction

    function void set_size(logic [23:0] v);
      img_size = v;
    endfunction

    function int pending();
      return runs_due.size();
    endfunction

    // Clip at the image size; a run that does not fit stops the decoder.
    function void push_run(logic [7:0] value, logic [7:0] len);
      brle_pkg::result_t r;
      logic [24:0]       room;
      room          = (img_size > wr_pos) ? {1'b0, img_size} - wr_pos : '0;
      r.start_index = wr_pos[23:0];
      r.pixel_value = value;
      if (len > room) begin
        r.run_length = room[7:0];
        r.last       = 1'b1;
        r.overflow   = 1'b1;
        wr_pos       = {1'b0, img_size};
        state        = HALTED;
      end else begin
        r.run_length = len;
        r.last       = 1'b0;
        r.overflow   = 1'b0;
        wr_pos       = wr_pos + len;
      end
      runs_due.push_back(r);
    endfunction

    function void note_code(logic [7:0] b, logic first);
      brle_pkg::result_t r;
      bytes_taken++;
      if (first) restart();
      if (state != HALTED) bytes_used++;
      case (state)
        EXP_CODE: begin
          held_code = b;
          state     = EXP_SECOND;
        end
        EXP_SECOND: begin
          if (held_code != 8'd0) begin
            state = EXP_CODE;
            push_run(b, held_code);
          end else if (b == brle_pkg::EscEob) begin
            r.start_index = wr_pos[23:0];
            r.run_length  = '0;
            r.pixel_value = '0;
            r.last        = 1'b1;
            r.overflow    = 1'b0;
            runs_due.push_back(r);
            state = HALTED;
          end else if (b == brle_pkg::EscEol || b == brle_pkg::EscDelta) begin
            // delta offsets are read back as an ordinary pair
            state = EXP_CODE;
          end else begin
            lit_left = b;
            lit_odd  = b[0];
            state    = IN_LITERAL;
          end
        end
        IN_LITERAL: begin
          lit_left = lit_left - 8'd1;
          if (lit_left == 8'd0) state = lit_odd ? AT_PAD : EXP_CODE;
          push_run(b, 8'd1);
        end
        AT_PAD: begin
          state = EXP_CODE;
        end
        default: ;
      endcase
    endfunction

    function void mismatch(string field, logic [23:0] want_v, logic [23:0] got_v);
      errors++;
      $display("%0t: run %0d %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, runs_seen, field, want_v, got_v);
    endfunction

    function void check_run(logic [39:0] data, logic last, logic ovf);
      brle_pkg::result_t want;
      if (runs_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected run: expected none, actual data=0x%0h last=%0b ovf=%0b",
                 $time, data, last, ovf);
        return;
      end
      want = runs_due.pop_front();
      runs_seen++;
      if (want.overflow) stops_seen++;
      else if (want.last) ends_seen++;
      if (data[7:0] !== want.pixel_value) mismatch("pixel_value", want.pixel_value, data[7:0]);
      if (data[15:8] !== want.run_length) mismatch("run_length", want.run_length, data[15:8]);
      if (data[39:16] !== want.start_index)
        mismatch("start_index", want.start_index, data[39:16]);
      if (last !== want.last) mismatch("last", want.last, last);
      if (ovf !== want.overflow) mismatch("overflow", want.overflow, ovf);
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  rle_run_scoreboard sb;
  bit          quiet        = 1'b0;
  bit          start_flag   = 1'b0;
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_stall_left = 0;
  int unsigned idle_cycles  = 0;
  int unsigned size_writes  = 0;

  bmp_rle8_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: stall in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready    <= 1'b1;
      rx_stall_left <= 0;
    end else if (rx_stall_left != 0) begin
      out_tready    <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      out_tready    <= 1'b0;
      rx_stall_left <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_size(cfg_wr_data);
      if (in_tvalid && in_tready) sb.note_code(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_run(out_tdata, out_tlast, out_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles, %0d runs still due",
               $time, idle_cycles, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_code(input logic [7:0] b);
    if (!quiet && tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= b;
    in_tuser   <= start_flag;
    start_flag = 1'b0;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every predicted run is out, then let the tail drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_size(input logic [23:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_writes++;
  endtask

  task automatic gen_image();
    int unsigned n_cmds;
    int unsigned c;
    int unsigned kind;
    int unsigned count;
    int unsigned k;
    logic [7:0]  code;
    start_flag = 1'b1;
    n_cmds = $urandom_range(1, 16);
    for (c = 0; c < n_cmds; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                           : 8'($urandom_range(1, 8));
        send_code(code);
        send_code(8'($urandom));
      end else if (kind < 58) begin
        send_code(8'h00);
        send_code(brle_pkg::EscEol);
      end else if (kind < 64) begin
        send_code(8'h00);
        send_code(brle_pkg::EscDelta);
        send_code(8'($urandom_range(1, 255)));
        send_code(8'($urandom));
      end else if (kind < 90) begin
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 16);
        send_code(8'h00);
        send_code(8'(count));
        for (k = 0; k < count; k++) begin
          // drop the image mid-literal now and then
          if ($urandom_range(0, 199) == 0) return;
          send_code(8'($urandom));
        end
        if (count % 2 == 1) send_code(8'($urandom));
      end else if (kind < 96) begin
        repeat ($urandom_range(1, 3)) send_code(8'($urandom));
      end else begin
        return;
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send_code(8'h00);
      send_code(brle_pkg::EscEob);
    end
    repeat ($urandom_range(0, 2)) send_code(8'($urandom));
  endtask

  initial begin
    logic [23:0] size;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full run, escapes, odd literal with pad.
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    write_size(24'd600);
    start_flag = 1'b1;
    send_code(8'hFF); send_code(8'hFF);
    send_code(8'h01); send_code(8'h00);
    send_code(8'h00); send_code(brle_pkg::EscEol);
    send_code(8'h00); send_code(brle_pkg::EscDelta); send_code(8'h03); send_code(8'h05);
    send_code(8'h00); send_code(8'h03);
    send_code(8'h11); send_code(8'h22); send_code(8'h33); send_code(8'h00);
    // Lower the size below the write position mid-stream.
    settle();
    write_size(24'd200);
    send_code(8'h02); send_code(8'h77);
    send_code(8'h07);
    // Exact fill, then end of bitmap.
    settle();
    write_size(24'd10);
    start_flag = 1'b1;
    send_code(8'h0A); send_code(8'h55);
    send_code(8'h00); send_code(brle_pkg::EscEob);
    // Zero size clips the first literal byte.
    settle();
    write_size(24'd0);
    start_flag = 1'b1;
    send_code(8'h00); send_code(8'h04); send_code(8'h9C);

    while (sb.bytes_taken < TotalBytes) begin
      if (sb.bytes_taken > QuietAfter) quiet = 1'b1;
      settle();
      case ($urandom_range(0, 6))
        0:       size = 24'd0;
        1:       size = 24'hFFFFFF;
        2:       size = 24'($urandom_range(1, 300));
        6:       size = 24'($urandom);
        default: size = 24'($urandom_range(300, 4000));
      endcase
      write_size(size);
      case ($urandom_range(0, 2))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 10;
        default: tx_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 10;
        default: rx_stall_pct = 35;
      endcase
      repeat ($urandom_range(1, 3)) gen_image();
    end

    settle();
    $display("Took %0d bytes, %0d of them live, into %0d runs: %0d end markers, %0d overflow stops,",
             sb.bytes_taken, sb.bytes_used, sb.runs_seen, sb.ends_seen, sb.stops_seen);
    $display("over %0d image size settings from zero to the 24-bit maximum.", size_writes);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
